### rtl/core/timer_slot_table_defines.svh
// assertion macros for the timer slot table
// used by the top level only; the assertion bodies are empty in synthesis
`ifndef TIMER_SLOT_TABLE_DEFINES_SVH
`define TIMER_SLOT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define TST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer_slot_table assertion failed");
`define TST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("timer_slot_table assertion failed");
`else
`define TST_ASSERT(lbl, clk, rst, prop)
`define TST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### rtl/core/tst_pkg.sv
// types, constants and codes shared by the timer slot table modules
// no dependencies
`timescale 1ns / 1ps

package tst_pkg;

   localparam int NUM_SLOTS_DEF  = 16;
   localparam int OP_W           = 2;
   localparam int NOW_W          = 48;
   localparam int DELAY_W        = 32;
   localparam int ID_W           = 32;
   localparam int SLOT_W         = 4;
   localparam int WAIT_W         = 16;
   // deadline = now + signed delay fits in 50 bits signed
   localparam int DL_W           = 50;
   // deadline - now fits in 51 bits signed
   localparam int DIFF_W         = 51;
   localparam int REQ_DATA_W     = 112;
   localparam int RSP_DATA_W     = 24;
   localparam logic [WAIT_W-1:0] MAX_WAIT_RESET = 16'd1000;

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_POLL  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SET_SCAN,
      ST_CLEAR,
      ST_POLL_PRIME,
      ST_POLL_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic {
      AR_ADD,
      AR_SUB
   } arith_mode_type;

   typedef struct packed {
      logic nonpos;
      logic below_best;
   } cmp_type;

   typedef struct packed {
      logic              any_active;
      logic [WAIT_W-1:0] wait_ms;
      logic              fired;
      logic [SLOT_W-1:0] slot;
      logic              status;
   } result_type;

endpackage

### rtl/core/tst_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/tst_arith.sv
// shared adder/subtractor with compare for deadline math
// depends on tst_pkg
`timescale 1ns / 1ps

module tst_arith
   import tst_pkg::*;
(
   input  arith_mode_type    mode,
   input  logic [DIFF_W-1:0] a,
   input  logic [DIFF_W-1:0] b,
   input  logic [WAIT_W-1:0] best,
   output logic [DIFF_W-1:0] res,
   output cmp_type           cmp
);

   logic              sub;
   logic [DIFF_W-1:0] b_op;

   assign sub  = (mode == AR_SUB);
   assign b_op = sub ? ~b : b;
   assign res  = a + b_op + DIFF_W'(sub);

   always_comb begin
      cmp.nonpos     = res[DIFF_W-1] || (res == '0);
      cmp.below_best = !res[DIFF_W-1] &&
                       (res < {{(DIFF_W-WAIT_W){1'b0}}, best});
   end

endmodule

### rtl/core/tst_seq.sv
// sequencer: slot flags, operation state machine, result register
// depends on tst_pkg; drives tst_ram and tst_arith through the top level
`timescale 1ns / 1ps

module tst_seq
   import tst_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output result_type            rsp_res,
   input  logic [WAIT_W-1:0]     max_wait,
   output logic                  ram_we,
   output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] ram_waddr,
   output logic [DL_W-1:0]       ram_wdata,
   output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] ram_raddr,
   input  logic [DL_W-1:0]       ram_rdata,
   output arith_mode_type        ar_mode,
   output logic [DIFF_W-1:0]     ar_a,
   output logic [DIFF_W-1:0]     ar_b,
   output logic [WAIT_W-1:0]     ar_best,
   input  logic [DIFF_W-1:0]     ar_res,
   input  cmp_type               ar_cmp
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [NOW_W-1:0]     now_ff, now_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        chk_ff, chk_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [WAIT_W-1:0]    best_ff, best_in;
   logic                 active_ff, active_in;
   result_type           res_ff, res_in;
   result_type           out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;
   logic [IW-1:0]        idx_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         used_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         used_ff    <= used_in;
         out_vld_ff <= out_vld_in;
      end
      op_ff     <= op_in;
      now_ff    <= now_in;
      delay_ff  <= delay_in;
      id_ff     <= id_in;
      idx_ff    <= idx_in;
      chk_ff    <= chk_in;
      best_ff   <= best_in;
      active_ff <= active_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   // read index stops at the last slot so the ram never sees a bad address
   assign idx_next = (idx_ff == LAST) ? idx_ff : idx_ff + IW'(1);

   // set adds now + delay, poll subtracts now from the stored deadline
   always_comb begin
      if (op_ff == OP_POLL) begin
         ar_mode = AR_SUB;
         ar_a    = {ram_rdata[DL_W-1], ram_rdata};
         ar_b    = {{(DIFF_W-NOW_W){1'b0}}, now_ff};
      end else begin
         ar_mode = AR_ADD;
         ar_a    = {{(DIFF_W-NOW_W){1'b0}}, now_ff};
         ar_b    = {{(DIFF_W-DELAY_W){delay_ff[DELAY_W-1]}}, delay_ff};
      end
   end

   assign ar_best   = best_ff;
   assign ram_raddr = idx_ff;
   assign ram_waddr = idx_ff;
   assign ram_wdata = ar_res[DL_W-1:0];

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      now_in     = now_ff;
      delay_in   = delay_ff;
      id_in      = id_ff;
      idx_in     = idx_ff;
      chk_in     = chk_ff;
      used_in    = used_ff;
      best_in    = best_ff;
      active_in  = active_ff;
      res_in     = res_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;

      if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = req_tuser;
               now_in    = req_tdata[NOW_W-1:0];
               delay_in  = req_tdata[NOW_W+DELAY_W-1:NOW_W];
               id_in     = req_tdata[NOW_W+DELAY_W+ID_W-1:NOW_W+DELAY_W];
               idx_in    = '0;
               chk_in    = '0;
               best_in   = max_wait;
               active_in = 1'b0;
               res_in    = '0;
               case (req_tuser)
                  OP_SET:   state_in = ST_SET_SCAN;
                  OP_CLEAR: state_in = ST_CLEAR;
                  OP_POLL:  state_in = ST_POLL_PRIME;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end

         ST_SET_SCAN: begin
            if (!used_ff[idx_ff]) begin
               used_in[idx_ff] = 1'b1;
               ram_we          = 1'b1;
               res_in.slot     = SLOT_W'(idx_ff);
               state_in        = ST_FINISH;
            end else if (idx_ff == LAST) begin
               res_in.status = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               idx_in = idx_next;
            end
         end

         ST_CLEAR: begin
            if ((id_ff < ID_W'(NUM_SLOTS)) && used_ff[id_ff[IW-1:0]]) begin
               used_in[id_ff[IW-1:0]] = 1'b0;
            end
            state_in = ST_FINISH;
         end

         ST_POLL_PRIME: begin
            chk_in   = idx_ff;
            idx_in   = idx_next;
            state_in = ST_POLL_SCAN;
         end

         ST_POLL_SCAN: begin
            if (used_ff[chk_ff]) begin
               active_in = 1'b1;
               if (ar_cmp.below_best) begin
                  best_in = ar_res[WAIT_W-1:0];
               end
            end
            if (used_ff[chk_ff] && ar_cmp.nonpos) begin
               used_in[chk_ff]   = 1'b0;
               res_in.fired      = 1'b1;
               res_in.slot       = SLOT_W'(chk_ff);
               res_in.wait_ms    = '0;
               res_in.any_active = 1'b1;
               state_in          = ST_FINISH;
            end else if (chk_ff == LAST) begin
               res_in.wait_ms    = best_in;
               res_in.any_active = active_in;
               state_in          = ST_FINISH;
            end else begin
               chk_in = idx_ff;
               idx_in = idx_next;
            end
         end

         ST_FINISH: begin
            if (!out_vld_ff || rsp_tready) begin
               out_in     = res_ff;
               out_vld_in = 1'b1;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_res    = out_ff;

endmodule

### rtl/core/timer_slot_table.sv
// Timer slot table: NUM_SLOTS one-shot timers with set, clear and poll.
// Request channel (req_*): one transaction per operation, opcode in tuser,
// now_ms, delay_ms and slot_id in tdata. Response channel (rsp_*): exactly one
// transaction per request with status, slot, fired, wait_ms and any_active.
// csr_wr_en / csr_wr_data write max_wait, the cap on a reported wait.
// Timing: a set scans the slot flags one slot per cycle until a free one is
// found; a poll walks the deadline ram one slot per cycle through one shared
// subtract/compare unit, after a priming step for the registered ram read.
// A clear updates the slot flag and then responds; an unused opcode goes
// straight to the response. One request is worked on at a time and req_tready is low
// meanwhile; it rises again in the cycle the response turns valid.
// The response sits in an output register, so the next request is accepted
// while it waits; a stalled receiver only holds the block once a second
// response is ready. Reset frees all slots, drops rsp_tvalid and sets
// max_wait to 1000. Deadline storage is not cleared: a slot's deadline is only
// used after it was set.
// depends on tst_pkg, tst_ram, tst_arith, tst_seq, timer_slot_table_defines.svh
`timescale 1ns / 1ps
`include "timer_slot_table_defines.svh"

module timer_slot_table
   import tst_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [1:0] opcode
   input  logic [OP_W-1:0]       req_tuser,
   // [47:0] now_ms, [79:48] delay_ms, [111:80] slot_id
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] status, [4:1] slot, [5] fired, [21:6] wait_ms, [22] any_active, [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [WAIT_W-1:0]     csr_wr_data
);

   localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [WAIT_W-1:0] max_wait_ff;
   logic [WAIT_W-1:0] max_wait_in;
   logic              ram_we;
   logic [IW-1:0]     ram_waddr;
   logic [DL_W-1:0]   ram_wdata;
   logic [IW-1:0]     ram_raddr;
   logic [DL_W-1:0]   ram_rdata;
   arith_mode_type    ar_mode;
   logic [DIFF_W-1:0] ar_a;
   logic [DIFF_W-1:0] ar_b;
   logic [WAIT_W-1:0] ar_best;
   logic [DIFF_W-1:0] ar_res;
   cmp_type           ar_cmp;
   result_type        rsp_res;

   assign max_wait_in = csr_wr_en ? csr_wr_data : max_wait_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wait_ff <= MAX_WAIT_RESET;
      end else begin
         max_wait_ff <= max_wait_in;
      end
   end

   tst_ram #(
      .WIDTH (DL_W),
      .DEPTH (NUM_SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tst_arith u_arith (
      .mode (ar_mode),
      .a    (ar_a),
      .b    (ar_b),
      .best (ar_best),
      .res  (ar_res),
      .cmp  (ar_cmp)
   );

   tst_seq #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res),
      .max_wait   (max_wait_ff),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .ar_mode    (ar_mode),
      .ar_a       (ar_a),
      .ar_b       (ar_b),
      .ar_best    (ar_best),
      .ar_res     (ar_res),
      .ar_cmp     (ar_cmp)
   );

   assign rsp_tdata = {1'b0, rsp_res.any_active, rsp_res.wait_ms, rsp_res.fired,
                       rsp_res.slot, rsp_res.status};

   // one operation at a time: no request right after an accepted one
   `TST_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready)
   // a fired slot reports zero wait and an active table
   `TST_ASSERT(a_fired_fields, clock, reset, (rsp_tvalid && rsp_res.fired) |-> ((rsp_res.wait_ms == '0) && rsp_res.any_active && !rsp_res.status))
   // a full table on set reports nothing else
   `TST_ASSERT(a_full_fields, clock, reset, (rsp_tvalid && rsp_res.status) |-> ((rsp_res.slot == '0) && !rsp_res.fired && (rsp_res.wait_ms == '0)))
   // no response survives reset
   `TST_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_tvalid)

endmodule
